@@ hw/rtl/spps_pkg.sv @@
// shared types and constants for the stepper profile pulse sequencer
// no dependencies; imported by stepper_profile_pulse_sequencer_core
package spps_pkg;

    // request kinds on the input channel
    localparam logic [1:0] REQ_WR_ACCEL = 2'd0;
    localparam logic [1:0] REQ_WR_DECEL = 2'd1;
    localparam logic [1:0] REQ_START    = 2'd2;
    localparam logic [1:0] REQ_COMPARE  = 2'd3;

    // motion phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ACCEL  = 3'd1;
    localparam logic [2:0] PH_CRUISE = 3'd2;
    localparam logic [2:0] PH_DECEL  = 3'd3;
    localparam logic [2:0] PH_STOP   = 3'd4;

    // move status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_NO_START = 2'd2;

    localparam int CLK_W   = 28;
    localparam int SPEED_W = 20;
    localparam int HALF_W  = 16;
    localparam logic [HALF_W-1:0] HALF_SAT = 16'hFFFF;
    localparam logic [10:0] PTR_MAX = 11'h7FF;
    localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

    typedef enum logic [4:0] {
        FSM_IDLE  = 5'b00001,
        FSM_ISSUE = 5'b00010,
        FSM_LOAD  = 5'b00100,
        FSM_DIV   = 5'b01000,
        FSM_FIN   = 5'b10000
    } fsm_t;

endpackage

@@ hw/rtl/stepper_profile_pulse_sequencer_core.sv @@
// stepper profile pulse sequencer, top level
// depends on spps_pkg; holds the speed table memories and the clock/speed divider
//
// usage:
//   s_ channel: one beat per request. s_tuser = {channel, req_type}; s_tdata carries
//   entry_index, speed_value, move_steps, ramp_up_steps, ramp_down_steps, cruise_speed
//   and timer_count. req_type selects an accel table write, decel table write,
//   start of a move or a compare event of the channel's timer.
//   m_ channel: exactly one result beat per request, in order. m_tuser = out_channel.
//   cfg_ channel: writes timer_clock_hz; always ready; user must write only while idle, unchecked.
// timing:
//   one request is worked on at a time. an accepted start or a compare event that steps
//   a running ramp or cruise runs the 28-step restoring divider (timer clock over speed):
//   the request passes the issue, load, divide and finish states, and the next beat is
//   taken once its result is committed. table writes, rejected starts and all other
//   events pass only the issue and finish states.
//   a finished result waits in the output register, and the next request is taken
//   while it waits; if the output register is still full when the next result is
//   ready, the sequencer holds that result until m_tready frees it.
// reset:
//   aresetn low clears all per-channel state to idle and zero and sets timer_clock_hz to
//   1000000. the speed tables are not cleared and must be written before use.
module stepper_profile_pulse_sequencer_core
    import spps_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int TABLE_DEPTH  = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index[9:0] speed_value[29:10] move_steps[61:30] ramp_up_steps[72:62]
    // ramp_down_steps[83:73] cruise_speed[103:84] timer_count[119:104]
    input  logic [119:0] s_tdata,
    // req_type[1:0] channel[3:2]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_compare[15:0] half_period[31:16] direction[32] phase[35:33]
    // stop_output[36] move_status[38:37] abs_position[70:39] zero[71]
    output logic [71:0]  m_tdata,
    // out_channel[1:0]
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [27:0]  cfg_data
);

    localparam int CIW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int TIW   = $clog2(TABLE_DEPTH);
    localparam int DEPTH = NUM_CHANNELS * TABLE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    // speed tables
    logic [SPEED_W-1:0] accel_mem [DEPTH];
    logic [SPEED_W-1:0] decel_mem [DEPTH];
    logic [SPEED_W-1:0] accel_rd_reg, decel_rd_reg;

    // per-channel state
    logic [2:0]         phase_reg    [NUM_CHANNELS];
    logic               toggle_reg   [NUM_CHANNELS];
    logic [30:0]        progress_reg [NUM_CHANNELS];
    logic [10:0]        ptr_reg      [NUM_CHANNELS];
    logic [30:0]        total_reg    [NUM_CHANNELS];
    logic [30:0]        dstart_reg   [NUM_CHANNELS];
    logic [10:0]        rlen_reg     [NUM_CHANNELS];
    logic [SPEED_W-1:0] crate_reg    [NUM_CHANNELS];
    logic [HALF_W-1:0]  half_reg     [NUM_CHANNELS];
    logic [31:0]        pos_reg      [NUM_CHANNELS];
    logic               dir_reg      [NUM_CHANNELS];

    logic [CLK_W-1:0] clk_hz_reg;
    fsm_t             fsm_reg;

    // latched request
    logic [1:0]         req_reg, ch_reg;
    logic [9:0]         idx_reg;
    logic [SPEED_W-1:0] spd_reg, cruise_reg;
    logic [31:0]        steps_reg;
    logic [10:0]        up_reg, down_reg;
    logic [15:0]        tcount_reg;

    // divider
    logic [SPEED_W:0]   rem_reg;
    logic [CLK_W-1:0]   quo_reg;
    logic [SPEED_W-1:0] dvsr_reg;
    logic [4:0]         cnt_reg;
    logic [SPEED_W+1:0] trial;

    // output register
    logic        m_valid_reg;
    logic [71:0] m_data_reg;
    logic [1:0]  m_user_reg;

    logic [CIW-1:0] chi;
    logic           ch_ok, step, need_div, start_ok, neg, commit;
    logic [31:0]    mag32;
    logic [30:0]    mag;
    logic [2:0]     cur_ph;
    logic [12:0]    ptr_ext;
    logic [TIW-1:0] rd_entry;
    logic [AW-1:0]  rd_addr, wr_addr;
    logic [HALF_W-1:0] div_half;

    assign chi      = CIW'(ch_reg);
    assign ch_ok    = 32'(ch_reg) < NUM_CHANNELS;
    assign cur_ph   = phase_reg[chi];
    assign step     = toggle_reg[chi];
    assign neg      = steps_reg[31];
    assign mag32    = neg ? (32'd0 - steps_reg) : steps_reg;
    assign mag      = mag32[31] ? MAG_MAX : mag32[30:0];
    assign start_ok = mag >= (31'(up_reg) + 31'(down_reg));

    always_comb begin
        need_div = 1'b0;
        if (ch_ok) begin
            if (req_reg == REQ_START) begin
                need_div = start_ok;
            end else if (req_reg == REQ_COMPARE) begin
                need_div = step && (cur_ph == PH_ACCEL || cur_ph == PH_CRUISE
                                    || cur_ph == PH_DECEL);
            end
        end
    end

    // table read address: entry 0 for a start, clamped pointer otherwise
    assign ptr_ext  = (req_reg == REQ_START) ? 13'd0 : 13'(ptr_reg[chi]);
    assign rd_entry = (ptr_ext >= 13'(TABLE_DEPTH)) ? TIW'(TABLE_DEPTH - 1) : TIW'(ptr_ext);
    assign rd_addr  = AW'(32'(chi) * TABLE_DEPTH) + AW'(rd_entry);
    assign wr_addr  = AW'(32'(chi) * TABLE_DEPTH) + AW'(idx_reg);

    always_ff @(posedge aclk) begin
        if (commit && ch_ok && req_reg == REQ_WR_ACCEL && 13'(idx_reg) < 13'(TABLE_DEPTH)) begin
            accel_mem[wr_addr] <= spd_reg;
        end
        accel_rd_reg <= accel_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (commit && ch_ok && req_reg == REQ_WR_DECEL && 13'(idx_reg) < 13'(TABLE_DEPTH)) begin
            decel_mem[wr_addr] <= spd_reg;
        end
        decel_rd_reg <= decel_mem[rd_addr];
    end

    // restoring divider step
    assign trial = {1'b0, rem_reg[SPEED_W-1:0], quo_reg[CLK_W-1]} - {2'b00, dvsr_reg};

    // floor(floor(clk / speed) / 2) with saturation
    always_comb begin
        if (dvsr_reg == '0 || quo_reg[CLK_W-1:HALF_W+1] != '0) begin
            div_half = HALF_SAT;
        end else begin
            div_half = quo_reg[HALF_W:1];
        end
    end

    assign commit = (fsm_reg == FSM_FIN) && (!m_valid_reg || m_tready);

    // result and state updates of the current request
    logic [2:0]        ph_next;
    logic              tog_next, dir_next, stop_flag;
    logic [30:0]       prog_next, total_next, dstart_next;
    logic [10:0]       ptr_next, rlen_next;
    logic [SPEED_W-1:0] crate_next;
    logic [HALF_W-1:0] half_next, cmp;
    logic [31:0]       pos_next;
    logic [1:0]        status;

    always_comb begin
        ph_next     = cur_ph;
        tog_next    = toggle_reg[chi];
        dir_next    = dir_reg[chi];
        prog_next   = progress_reg[chi];
        total_next  = total_reg[chi];
        dstart_next = dstart_reg[chi];
        ptr_next    = ptr_reg[chi];
        rlen_next   = rlen_reg[chi];
        crate_next  = crate_reg[chi];
        half_next   = half_reg[chi];
        pos_next    = pos_reg[chi];
        stop_flag   = 1'b0;
        cmp         = '0;
        status      = ST_NO_START;
        unique case (req_reg)
            REQ_START: begin
                dir_next = neg;
                if (start_ok) begin
                    total_next  = mag;
                    dstart_next = mag - 31'(down_reg);
                    rlen_next   = up_reg;
                    crate_next  = cruise_reg;
                    prog_next   = '0;
                    ph_next     = PH_ACCEL;
                    half_next   = div_half;
                    ptr_next    = 11'd1;
                    cmp         = div_half;
                    status      = ST_OK;
                end else begin
                    status = ST_REJECTED;
                end
            end
            REQ_COMPARE: begin
                tog_next = ~toggle_reg[chi];
                if (step) begin
                    pos_next = pos_reg[chi] + 32'd1;
                    if (cur_ph != PH_IDLE && cur_ph != PH_STOP) begin
                        prog_next = progress_reg[chi] + 31'd1;
                    end
                    priority if (cur_ph == PH_ACCEL) begin
                        half_next = div_half;
                        ptr_next  = (ptr_reg[chi] == PTR_MAX) ? PTR_MAX : ptr_reg[chi] + 11'd1;
                        if (prog_next >= 31'(rlen_reg[chi])) ph_next = PH_CRUISE;
                    end else if (cur_ph == PH_DECEL) begin
                        half_next = div_half;
                        ptr_next  = (ptr_reg[chi] == PTR_MAX) ? PTR_MAX : ptr_reg[chi] + 11'd1;
                        if (prog_next >= total_reg[chi]) ph_next = PH_STOP;
                    end else if (cur_ph == PH_CRUISE) begin
                        half_next = div_half;
                        if (prog_next >= dstart_reg[chi]) begin
                            ptr_next = '0;
                            ph_next  = PH_DECEL;
                        end
                    end else if (cur_ph == PH_STOP) begin
                        stop_flag = 1'b1;
                        ph_next   = PH_IDLE;
                    end else begin
                        ph_next = PH_IDLE;
                    end
                end
                cmp = tcount_reg + half_next;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= FSM_IDLE;
            clk_hz_reg  <= 28'd1000000;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                phase_reg[i]    <= PH_IDLE;
                toggle_reg[i]   <= 1'b0;
                progress_reg[i] <= '0;
                ptr_reg[i]      <= '0;
                total_reg[i]    <= '0;
                dstart_reg[i]   <= '0;
                rlen_reg[i]     <= '0;
                crate_reg[i]    <= '0;
                half_reg[i]     <= '0;
                pos_reg[i]      <= '0;
                dir_reg[i]      <= 1'b0;
            end
        end else begin
            if (cfg_valid) begin
                clk_hz_reg <= cfg_data;
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (fsm_reg)
                FSM_IDLE: begin
                    if (s_tvalid) begin
                        fsm_reg <= FSM_ISSUE;
                    end
                end
                FSM_ISSUE: begin
                    fsm_reg <= need_div ? FSM_LOAD : FSM_FIN;
                end
                FSM_LOAD: begin
                    fsm_reg <= FSM_DIV;
                end
                FSM_DIV: begin
                    if (cnt_reg == 5'(CLK_W - 1)) begin
                        fsm_reg <= FSM_FIN;
                    end
                end
                FSM_FIN: begin
                    if (commit) begin
                        fsm_reg     <= FSM_IDLE;
                        m_valid_reg <= 1'b1;
                        if (ch_ok) begin
                            phase_reg[chi]    <= ph_next;
                            toggle_reg[chi]   <= tog_next;
                            progress_reg[chi] <= prog_next;
                            ptr_reg[chi]      <= ptr_next;
                            total_reg[chi]    <= total_next;
                            dstart_reg[chi]   <= dstart_next;
                            rlen_reg[chi]     <= rlen_next;
                            crate_reg[chi]    <= crate_next;
                            half_reg[chi]     <= half_next;
                            pos_reg[chi]      <= pos_next;
                            dir_reg[chi]      <= dir_next;
                        end
                    end
                end
                default: fsm_reg <= FSM_IDLE;
            endcase
        end
    end

    // request capture, divider and output payload
    always_ff @(posedge aclk) begin
        if (fsm_reg == FSM_IDLE && s_tvalid) begin
            req_reg    <= s_tuser[1:0];
            ch_reg     <= s_tuser[3:2];
            idx_reg    <= s_tdata[9:0];
            spd_reg    <= s_tdata[29:10];
            steps_reg  <= s_tdata[61:30];
            up_reg     <= s_tdata[72:62];
            down_reg   <= s_tdata[83:73];
            cruise_reg <= s_tdata[103:84];
            tcount_reg <= s_tdata[119:104];
        end
        if (fsm_reg == FSM_LOAD) begin
            rem_reg <= '0;
            quo_reg <= clk_hz_reg;
            cnt_reg <= '0;
            if (req_reg == REQ_COMPARE && cur_ph == PH_CRUISE) begin
                dvsr_reg <= crate_reg[chi];
            end else if (req_reg == REQ_COMPARE && cur_ph == PH_DECEL) begin
                dvsr_reg <= decel_rd_reg;
            end else begin
                dvsr_reg <= accel_rd_reg;
            end
        end
        if (fsm_reg == FSM_DIV) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (!trial[SPEED_W+1]) begin
                rem_reg <= trial[SPEED_W:0];
                quo_reg <= {quo_reg[CLK_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[SPEED_W-1:0], quo_reg[CLK_W-1]};
                quo_reg <= {quo_reg[CLK_W-2:0], 1'b0};
            end
        end
        if (commit) begin
            m_user_reg <= ch_reg;
            if (ch_ok) begin
                m_data_reg <= {1'b0, pos_next, status, stop_flag, ph_next, dir_next,
                               half_next, cmp};
            end else begin
                m_data_reg <= {33'd0, ST_NO_START, 37'd0};
            end
        end
    end

    assign s_tready  = (fsm_reg == FSM_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // one request at a time: no new beat right after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in flight");

    // an accepted start always leaves the channel accelerating
    a_start_accel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[38:37] == ST_OK) |-> (m_tdata[35:33] == PH_ACCEL))
        else $error("accepted start not in accel phase");

    // stop pulse is reported only together with the return to idle
    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[36]) |-> (m_tdata[35:33] == PH_IDLE))
        else $error("stop output without idle phase");

    // the divider runs only for requests that need it
    a_div_needed: assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == FSM_LOAD) |-> $past(need_div))
        else $error("divider started without need");

endmodule
